// ----- hw/rtl/tfr_pkg.sv -----
// Shared types and constants for the texel format to RGBA8 converter.
`timescale 1ns / 1ps
package tfr_pkg;

    localparam int TEXEL_W   = 32;
    localparam int COLOR_W   = 32;
    localparam int PADDR_W   = 8;
    localparam int FMT_W     = 6;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 32;

    localparam logic [FMT_W-1:0] FMT_CT32 = 6'h00;
    localparam logic [FMT_W-1:0] FMT_CT24 = 6'h01;
    localparam logic [FMT_W-1:0] FMT_CT16 = 6'h02;
    localparam logic [FMT_W-1:0] FMT_IDX8 = 6'h13;
    localparam logic [FMT_W-1:0] FMT_IDX4 = 6'h14;

    localparam logic ACT_CONVERT   = 1'b0;
    localparam logic ACT_PAL_WRITE = 1'b1;

    localparam logic CFG_PIXEL_FORMAT  = 1'b0;
    localparam logic CFG_PALETTE_VALID = 1'b1;

    localparam logic [COLOR_W-1:0] COLOR_MAGENTA = 32'hFFFF00FF;

    // floor(v * 255 / 31) for a 5-bit channel
    localparam logic [7:0] EXPAND5_LUT [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    typedef struct packed {
        logic               status;
        logic [COLOR_W-1:0] rgba;
    } pixel_t;

endpackage

// ----- hw/rtl/tfr_palette.sv -----
// Palette memory: one write port, one registered read port.
`timescale 1ns / 1ps
module tfr_palette #(
    parameter int PALETTE_DEPTH = 256,
    parameter int AW            = 8
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [tfr_pkg::COLOR_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [tfr_pkg::COLOR_W-1:0] rd_data
);
    import tfr_pkg::*;

    logic [COLOR_W-1:0] mem [PALETTE_DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/tfr_convert.sv -----
// Format decode and color expansion for one texel.
`timescale 1ns / 1ps
module tfr_convert (
    input  logic [tfr_pkg::FMT_W-1:0]   pixel_format,
    input  logic                        palette_valid,
    input  logic [tfr_pkg::TEXEL_W-1:0] texel,
    input  logic                        idx_in_range,
    input  logic [tfr_pkg::COLOR_W-1:0] pal_data,
    output tfr_pkg::pixel_t             pixel
);
    import tfr_pkg::*;

    always_comb begin
        pixel.status = 1'b0;
        pixel.rgba   = '0;
        unique case (pixel_format)
            FMT_CT32: begin
                pixel.rgba = texel;
            end
            FMT_CT24: begin
                pixel.rgba = {8'hFF, texel[23:0]};
            end
            FMT_CT16: begin
                pixel.rgba = {{8{texel[15]}},
                              EXPAND5_LUT[texel[14:10]],
                              EXPAND5_LUT[texel[9:5]],
                              EXPAND5_LUT[texel[4:0]]};
            end
            FMT_IDX8, FMT_IDX4: begin
                if (!palette_valid) begin
                    pixel.status = 1'b1;
                end else if (idx_in_range) begin
                    pixel.rgba = pal_data;
                end
            end
            default: begin
                pixel.rgba = COLOR_MAGENTA;
            end
        endcase
    end

endmodule

// ----- hw/rtl/texel_format_to_rgba8_top.sv -----
// Texel format to RGBA8 converter top level.
// Each input item is registered at the palette read and then in the output register.
// Throughput: one item per cycle while m_tready does not stall; palette writes and converts
// may alternate freely, since a write lands at its accept edge, before any later item's read.
// Reset: synchronous active-low aresetn clears config registers and valid flags;
// palette contents are undefined until written.
`timescale 1ns / 1ps
module texel_format_to_rgba8_top #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [tfr_pkg::FMT_W-1:0]     cfg_data,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tfr_pkg::S_TDATA_W-1:0] s_tdata,  // texel[31:0], palette_addr[39:32], palette_color[71:40]
    input  logic                          s_tuser,  // action
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tfr_pkg::M_TDATA_W-1:0] m_tdata,  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic                          m_tuser   // status
);
    import tfr_pkg::*;

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [FMT_W-1:0] fmt_reg;
    logic             pal_valid_reg;

    logic [TEXEL_W-1:0] in_texel;
    logic [PADDR_W-1:0] in_addr;
    logic [COLOR_W-1:0] in_color;
    logic               s_accept;
    logic               advance;
    logic [PADDR_W-1:0] rd_index;

    logic               s1_valid_reg, s1_valid_next;
    logic [TEXEL_W-1:0] s1_texel_reg;
    logic               s1_inrange_reg;
    logic [COLOR_W-1:0] pal_data;
    pixel_t             pixel;

    logic               m_valid_reg, m_valid_next;
    pixel_t             m_pixel_reg;

    assign in_texel = s_tdata[31:0];
    assign in_addr  = s_tdata[39:32];
    assign in_color = s_tdata[71:40];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg       <= '0;
            pal_valid_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PIXEL_FORMAT:  fmt_reg       <= cfg_data;
                CFG_PALETTE_VALID: pal_valid_reg <= cfg_data[0];
            endcase
        end
    end

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign rd_index = (fmt_reg == FMT_IDX4) ? {4'b0, in_texel[3:0]} : in_texel[7:0];

    tfr_palette #(
        .PALETTE_DEPTH(PALETTE_DEPTH),
        .AW           (AW)
    ) u_palette (
        .aclk   (aclk),
        .wr_en  (s_accept && (s_tuser == ACT_PAL_WRITE)
                 && ({1'b0, in_addr} < 9'(PALETTE_DEPTH))),
        .wr_addr(in_addr[AW-1:0]),
        .wr_data(in_color),
        .rd_en  (s_accept && (s_tuser == ACT_CONVERT)),
        .rd_addr(rd_index[AW-1:0]),
        .rd_data(pal_data)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept && (s_tuser == ACT_CONVERT)) begin
            s1_valid_next = 1'b1;
        end else if (s1_valid_reg && advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && (s_tuser == ACT_CONVERT)) begin
            s1_texel_reg   <= in_texel;
            s1_inrange_reg <= {1'b0, rd_index} < 9'(PALETTE_DEPTH);
        end
    end

    tfr_convert u_convert (
        .pixel_format (fmt_reg),
        .palette_valid(pal_valid_reg),
        .texel        (s1_texel_reg),
        .idx_in_range (s1_inrange_reg),
        .pal_data     (pal_data),
        .pixel        (pixel)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_valid_reg && advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && advance) begin
            m_pixel_reg <= pixel;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pixel_reg.rgba;
    assign m_tuser  = m_pixel_reg.status;

endmodule
